/* rtl/core/rtpdp_pkg.sv */
// ----------------------------------------------------------------------------
// RTP datagram packetizer package
// Shared constants and beat types for the packetizer front, queue and back.
// ----------------------------------------------------------------------------
package rtpdp_pkg;

    localparam int DATAGRAM_BYTES = 1400;
    localparam int FILL_W         = 14;
    localparam int HDR_LEN        = 12;
    localparam int IDX_W          = 4;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = 2;

    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0] RTP_PAYLOAD_TYPE = 8'd96;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        frame_first;
        logic        frame_last;
        logic [31:0] frame_time;
    } item_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       datagram_end;
        logic       run_end;
    } result_beat_t;

    // One classified item waiting for the back end.
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        with_header;
        logic        early_close;
        logic [15:0] seq;
        logic [31:0] stamp;
    } work_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* rtl/core/rtpdp_front.sv */
// ----------------------------------------------------------------------------
// RTP packetizer front end
// Accepts payload beats, decides on header insertion and early close, and
// tracks sequence count, datagram fill and the frame timestamp.
// ----------------------------------------------------------------------------
module rtpdp_front
    import rtpdp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  item_beat_t    item,
    input  queue_status_t qstat,
    output logic          push,
    output work_entry_t   entry
);

    localparam logic [FILL_W:0]   DGRAM_X  = (FILL_W+1)'(DATAGRAM_BYTES);
    localparam logic [FILL_W-1:0] CLOSE_AT = FILL_W'(DATAGRAM_BYTES - (HDR_LEN + 1));

    logic [15:0]       seq_reg,  seq_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [31:0]       time_reg, time_next;

    logic              with_header;
    logic [FILL_W:0]   sum;
    logic              wrap;
    logic [FILL_W-1:0] fill_after;
    logic              early;

    assign push = item_valid && !qstat.full;

    always_comb
    begin
        with_header = item.frame_first || (fill_reg == '0);
        time_next   = item.frame_first ? item.frame_time : time_reg;
        sum         = {1'b0, fill_reg}
                    + (with_header ? (FILL_W+1)'(HDR_LEN + 1) : (FILL_W+1)'(1));
        wrap        = (sum >= DGRAM_X);
        fill_after  = wrap ? FILL_W'(sum - DGRAM_X) : sum[FILL_W-1:0];
        // A wrap leaves fewer than 13 bytes, which never meets the early close.
        early       = item.frame_last && (fill_after != '0) && (fill_after > CLOSE_AT);
        fill_next   = early ? '0 : fill_after;
        seq_next    = seq_reg + 16'(wrap || early);

        entry.payload_byte = item.payload_byte;
        entry.with_header  = with_header;
        entry.early_close  = early;
        entry.seq          = seq_reg;
        entry.stamp        = time_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg  <= '0;
            fill_reg <= '0;
            time_reg <= '0;
        end
        else if (push)
        begin
            seq_reg  <= seq_next;
            fill_reg <= fill_next;
            time_reg <= time_next;
        end
    end

endmodule

/* rtl/core/rtpdp_queue.sv */
// ----------------------------------------------------------------------------
// RTP packetizer work queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module rtpdp_queue
    import rtpdp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  work_entry_t   push_entry,
    input  logic          pop,
    output work_entry_t   head,
    output queue_status_t qstat
);

    work_entry_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign qstat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

endmodule

/* rtl/core/rtpdp_back.sv */
// ----------------------------------------------------------------------------
// RTP packetizer back end
// Walks each queued item out as header bytes, if it has one, and its payload
// byte, marks datagram ends and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module rtpdp_back
    import rtpdp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  work_entry_t   head,
    input  queue_status_t qstat,
    input  logic [31:0]   source_id,
    output logic          pop,
    output logic          result_valid,
    input  logic          result_stall,
    output result_beat_t  result
);

    localparam logic [FILL_W-1:0] LAST_FILL = FILL_W'(DATAGRAM_BYTES - 1);

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              valid_reg;
    result_beat_t      beat_reg, beat_next;

    logic [8*HDR_LEN-1:0] hdr_vec;
    logic [IDX_W-1:0]     sel;
    logic                 can_emit;
    logic                 is_pay;

    always_comb
    begin
        hdr_vec  = {RTP_VERSION_BYTE, RTP_PAYLOAD_TYPE, head.seq, head.stamp, source_id};
        sel      = IDX_W'(HDR_LEN - 1) - idx_reg;
        can_emit = !qstat.empty && (!valid_reg || !result_stall);
        is_pay   = !head.with_header || (idx_reg == IDX_W'(HDR_LEN));
        pop      = can_emit && is_pay;

        beat_next.out_byte     = is_pay ? head.payload_byte : hdr_vec[{sel, 3'b000} +: 8];
        beat_next.datagram_end = (fill_reg == LAST_FILL) || (is_pay && head.early_close);
        beat_next.run_end      = is_pay;
        fill_next              = beat_next.datagram_end ? '0 : fill_reg + 1'b1;
        idx_next               = is_pay ? '0 : idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (can_emit)
        begin
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_emit)
        begin
            beat_reg <= beat_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = beat_reg;

endmodule

/* rtl/core/rtp_datagram_packetizer_unit.sv */
// ----------------------------------------------------------------------------
// RTP datagram packetizer
// Cuts a payload byte stream into datagrams of up to 1400 bytes with RTP headers.
//
// Channel  Direction  Handshake            Beat
// item     in         item_valid/stall     item_beat_t (one payload byte)
// result   out        result_valid/stall   result_beat_t (one datagram byte)
// cfg      in         cfg_valid/ready      32-bit source id
//
// A payload byte with no header leaves as a single beat; one that opens a frame
// or a datagram leaves as 13 beats, as the back end outputs a single byte per
// cycle while the output is not stalled. A four-entry queue lets the front keep
// accepting while the back end emits headers or the output is stalled.
// An accepted item passes through a queue slot, then the output register; a stall
// or earlier items can hold it. Reset clears all state but the queue slots and output beat.
// ----------------------------------------------------------------------------
module rtp_datagram_packetizer_unit
    import rtpdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  item_beat_t   item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_beat_t result,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);

    logic [31:0]   source_id_reg;
    logic          push;
    logic          pop;
    work_entry_t   push_entry;
    work_entry_t   head;
    queue_status_t qstat;

    assign cfg_ready  = 1'b1;
    assign item_stall = qstat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_id_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            source_id_reg <= cfg_data;
        end
    end

    rtpdp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .qstat      (qstat),
        .push       (push),
        .entry      (push_entry)
    );

    rtpdp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    rtpdp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .qstat        (qstat),
        .source_id    (source_id_reg),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
